@@ hw/rtl/bba_pkg.sv @@
package bba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int ACTION_W  = 2;
  localparam int BLOCK_W   = 12;
  localparam int COUNT_W   = 13;

  localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_TEST  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_WB
  } state_t;

  // lowest free bit of one map word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } srch_res_t;

endpackage

@@ hw/rtl/bba_word_search.sv @@
module bba_word_search (
  input  logic [bba_pkg::WORD_BITS-1:0] word,
  input  logic [bba_pkg::BIT_W:0]       valid_bits,
  output bba_pkg::srch_res_t            res
);
  import bba_pkg::*;

  localparam int CNT_W = BIT_W + 1;

  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     idx;

  always_comb begin
    // free bits that lie below the search limit
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = ~word[i] & (CNT_W'(i) < valid_bits);
    end
    // isolate lowest free bit, then encode it
    lowest = avail & (~avail + WORD_BITS'(1));
    idx    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    res.found = |avail;
    res.idx   = idx;
  end

endmodule

@@ hw/rtl/bitmap_block_allocator_top.sv @@
// First-fit block allocator over a used-bit map held in a single-port-style
// memory of 32-bit words (BLOCK_COUNT/32 words, 128 by default). Allocate
// returns the lowest free block below min(cfg limit, BLOCK_COUNT), marks it
// used and reports the new used count; status is 1 when nothing is free.
// Free clears one block's bit, test reports it, clear empties the whole map.
// Every request yields exactly one result transaction. Timing: the map is
// read one word per cycle through one shared word-search unit, so an
// allocate ends at the first word that holds a free block below the limit,
// or at the last word below it; free and test read only the word that holds
// their block, and clear zeroes every map word. in_ready comes back in the
// cycle after the result is loaded. A result that finds the previous one
// still waiting in the output register holds the block in write-back until
// out_ready frees the slot. After reset the block runs a clearing pass over
// every map word with in_ready low; cfg writes are always taken. The block
// holds one request at a time; a finished result waits in the output
// register, and the next request may be accepted meanwhile.
module bitmap_block_allocator_top #(
  parameter int BLOCK_COUNT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bba_pkg::COUNT_W-1:0]  cfg_block_limit,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bba_pkg::ACTION_W-1:0] in_action,
  input  logic [bba_pkg::BLOCK_W-1:0]  in_block,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [bba_pkg::BLOCK_W-1:0]  out_granted_block,
  output logic                         out_was_used,
  output logic [bba_pkg::COUNT_W-1:0]  out_used_count
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(BLOCK_COUNT + 1);
  localparam int LW        = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

  localparam logic [LW-1:0]  MAP_LIMIT = LW'(BLOCK_COUNT);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);

  // control state
  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   total_r;
  logic [COUNT_W-1:0]   used_total_r;
  logic [WAW-1:0]       clr_addr_r;
  logic                 clr_req_r;
  logic                 out_valid_r;

  // map memory and its registered read port
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WAW-1:0]       rd_addr_r;

  // request being worked on
  logic [ACTION_W-1:0]  action_r;
  logic [BLOCK_W-1:0]   block_r;

  // pending result and write-back
  logic                 res_status_r;
  logic [BLOCK_W-1:0]   res_gb_r;
  logic                 res_was_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic                 wr_en_r;
  logic [WAW-1:0]       wr_addr_r;
  logic [WORD_BITS-1:0] wr_data_r;

  // output register
  logic                 out_status_r;
  logic [BLOCK_W-1:0]   out_gb_r;
  logic                 out_was_r;
  logic [COUNT_W-1:0]   out_count_r;

  // memory port controls
  logic                 mem_re;
  logic [WAW-1:0]       mem_ra;
  logic                 mem_we;
  logic [WAW-1:0]       mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  // decision of the current request
  logic                 dec;
  logic                 dec_status;
  logic [BLOCK_W-1:0]   dec_gb;
  logic                 dec_was;
  logic [COUNT_W-1:0]   dec_count;
  logic                 dec_wr_en;
  logic [WORD_BITS-1:0] dec_wr_data;

  logic                 out_load;
  logic                 slot_free;
  logic                 in_accept;

  // search window and address math
  logic [LW-1:0]        total_ext;
  logic [LW-1:0]        limit;
  logic [LW-1:0]        base;
  logic [LW-1:0]        base_end;
  logic [LW-1:0]        diff;
  logic                 last_word;
  logic [BIT_W:0]       valid_bits;
  logic [LW-1:0]        in_block_ext;
  logic [LW-1:0]        block_ext;
  logic [LW-1:0]        grant_ext;
  logic                 in_map;
  logic                 was_bit;
  srch_res_t            srch;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // allocate may only hand out blocks below both the register and the map size
  assign total_ext = LW'(total_r);
  assign limit     = (total_ext > MAP_LIMIT) ? MAP_LIMIT : total_ext;

  // word under evaluation covers blocks base .. base+31
  assign base      = LW'({rd_addr_r, {BIT_W{1'b0}}});
  assign base_end  = base + LW'(WORD_BITS);
  assign diff      = limit - base;
  assign last_word = base_end >= limit;

  always_comb begin
    if (limit <= base) begin
      valid_bits = '0;
    end else if (diff >= LW'(WORD_BITS)) begin
      valid_bits = (BIT_W + 1)'(WORD_BITS);
    end else begin
      valid_bits = diff[BIT_W:0];
    end
  end

  // shared word-search unit, reused for every word of the scan
  bba_word_search u_search (
    .word       (rd_data_r),
    .valid_bits (valid_bits),
    .res        (srch)
  );

  assign grant_ext    = LW'({rd_addr_r, srch.idx});
  assign in_block_ext = LW'(in_block);
  assign block_ext    = LW'(block_r);
  // blocks past the map are never used and cannot be freed
  assign in_map       = block_ext < MAP_LIMIT;
  assign was_bit      = in_map && rd_data_r[block_r[BIT_W-1:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = clr_req_r ? ST_WB : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action) inside
            ACT_ALLOC:          state_nxt = ST_SCAN;
            ACT_FREE, ACT_TEST: state_nxt = ST_CHECK;
            ACT_CLEAR:          state_nxt = ST_CLEAR;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (srch.found || last_word) begin
          state_nxt = ST_WB;
        end
      end
      ST_CHECK: state_nxt = ST_WB;
      ST_WB: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    in_ready    = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    dec         = 1'b0;
    dec_status  = 1'b0;
    dec_gb      = '0;
    dec_was     = 1'b0;
    dec_count   = used_total_r;
    dec_wr_en   = 1'b0;
    dec_wr_data = rd_data_r;
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        // one word zeroed per cycle
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        if (clr_addr_r == LAST_WORD && clr_req_r) begin
          dec       = 1'b1;
          dec_count = '0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        // start the first read in the acceptance cycle
        mem_re   = in_valid;
        mem_ra   = (in_action == ACT_ALLOC) ? '0 : in_block_ext[WAW+BIT_W-1:BIT_W];
      end
      ST_SCAN: begin
        if (srch.found) begin
          dec         = 1'b1;
          dec_gb      = grant_ext[BLOCK_W-1:0];
          dec_count   = used_total_r + COUNT_W'(1);
          dec_wr_en   = 1'b1;
          dec_wr_data = rd_data_r | (WORD_BITS'(1) << srch.idx);
        end else if (last_word) begin
          // nothing free below the limit
          dec        = 1'b1;
          dec_status = 1'b1;
        end else begin
          mem_re = 1'b1;
          mem_ra = rd_addr_r + WAW'(1);
        end
      end
      ST_CHECK: begin
        dec     = 1'b1;
        dec_was = was_bit;
        if (action_r == ACT_FREE && was_bit) begin
          dec_count   = used_total_r - COUNT_W'(1);
          dec_wr_en   = 1'b1;
          dec_wr_data = rd_data_r & ~(WORD_BITS'(1) << block_r[BIT_W-1:0]);
        end
      end
      ST_WB: begin
        // commit map word and count together with the result transaction
        mem_we   = wr_en_r && slot_free;
        mem_wa   = wr_addr_r;
        mem_wd   = wr_data_r;
        out_load = slot_free;
      end
      default: ;
    endcase
  end

  // map memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
      rd_addr_r <= mem_ra;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      total_r      <= TOTAL_RESET;
      used_total_r <= '0;
      clr_addr_r   <= '0;
      clr_req_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        total_r <= cfg_block_limit;
      end
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + WAW'(1);
      end
      if (in_accept) begin
        clr_addr_r <= '0;
        clr_req_r  <= (in_action == ACT_CLEAR);
      end
      if (out_load) begin
        used_total_r <= res_count_r;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request, pending result and output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r <= in_action;
      block_r  <= in_block;
    end
    if (dec) begin
      res_status_r <= dec_status;
      res_gb_r     <= dec_gb;
      res_was_r    <= dec_was;
      res_count_r  <= dec_count;
      wr_en_r      <= dec_wr_en;
      wr_addr_r    <= rd_addr_r;
      wr_data_r    <= dec_wr_data;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_gb_r     <= res_gb_r;
      out_was_r    <= res_was_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_gb_r;
  assign out_was_used      = out_was_r;
  assign out_used_count    = out_count_r;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int MAP_BLOCKS  = 4096;
  localparam int PHASES      = 4;
  localparam int PHASE_REQS  = 90;
  localparam int FILL_BLOCKS = 64;

  // one result transaction as the block reports it
  typedef struct packed {
    logic               status;
    logic [BLOCK_W-1:0] granted;
    logic               was_used;
    logic [COUNT_W-1:0] count;
  } alloc_result_t;

  // one row of the directed table: either a limit register write or a request,
  // with the answer typed in when it is obvious from the spec
  typedef struct packed {
    logic               is_cfg;
    logic               typed;
    action_t            act;
    logic [BLOCK_W-1:0] blk;
    logic [COUNT_W-1:0] total;
    alloc_result_t      want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_block_limit = TOTAL_RESET;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action = ACT_TEST;
  logic [BLOCK_W-1:0]  in_block = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status;
  logic [BLOCK_W-1:0] out_granted_block;
  logic               out_was_used;
  logic [COUNT_W-1:0] out_used_count;

  // shadow copy of the allocator: used bits, used count, configured total
  bit                 shadow_used[MAP_BLOCKS];
  logic [COUNT_W-1:0] shadow_count = '0;
  logic [COUNT_W-1:0] shadow_total = TOTAL_RESET;

  alloc_result_t pending_results[$];
  directed_row_t directed_rows[$];

  int error_count = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int full_reports = 0;
  int grant_peak = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;

  int phase_gap_pct[PHASES]   = '{0, 57, 0, 34};
  int phase_stall_pct[PHASES] = '{0, 0, 57, 34};

  bitmap_block_allocator_top #(
    .BLOCK_COUNT(MAP_BLOCKS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_block_limit   (cfg_block_limit),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_block          (in_block),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_was_used      (out_was_used),
    .out_used_count    (out_used_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one request to the shadow map and returns what the block must report
  function automatic alloc_result_t serve_request(action_t act, logic [BLOCK_W-1:0] blk);
    alloc_result_t r;
    int limit;
    r = '0;
    case (act)
      ACT_ALLOC: begin
        // first fit below the total, clipped to the map size
        limit = (shadow_total > MAP_BLOCKS) ? MAP_BLOCKS : int'(shadow_total);
        r.status = 1'b1;
        for (int b = 0; b < limit; b++) begin
          if (!shadow_used[b]) begin
            shadow_used[b] = 1'b1;
            shadow_count++;
            r.status = 1'b0;
            r.granted = b[BLOCK_W-1:0];
            break;
          end
        end
      end
      ACT_FREE: begin
        // freeing a free block leaves the count alone
        r.was_used = shadow_used[blk];
        if (shadow_used[blk]) begin
          shadow_used[blk] = 1'b0;
          shadow_count--;
        end
      end
      ACT_TEST: begin
        r.was_used = shadow_used[blk];
      end
      default: begin
        foreach (shadow_used[b]) shadow_used[b] = 1'b0;
        shadow_count = '0;
      end
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // sender side: optional idle gap, then hold the request until it is taken
  task automatic issue_request(action_t act, logic [BLOCK_W-1:0] blk, logic typed,
                               alloc_result_t want);
    alloc_result_t predicted;
    while ($urandom_range(99, 0) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_block  <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transaction accepted at this edge
    predicted = serve_request(act, blk);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // drain everything outstanding before touching the register
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_total(logic [COUNT_W-1:0] total);
    cfg_valid       <= 1'b1;
    cfg_block_limit <= total;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    shadow_total = total;
  endtask

  // result side: random backpressure plus the in-order scoreboard
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_status) full_reports++;
      if (int'(out_granted_block) > grant_peak) grant_peak = int'(out_granted_block);
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_granted_block !== want.granted)
          report_mismatch("granted_block", out_granted_block, want.granted);
        if (out_was_used !== want.was_used)
          report_mismatch("was_used", out_was_used, want.was_used);
        if (out_used_count !== want.count)
          report_mismatch("used_count", out_used_count, want.count);
      end
    end
    out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    action_t            act;
    logic [BLOCK_W-1:0] blk;
    logic [COUNT_W-1:0] total;
    int                 roll;
    int                 hi;
    directed_row_t      row;

    // directed table: status, granted, was_used, count in the last group
    // fresh map, first grants, free of a free block, free of a used one
    directed_rows.push_back('{1'b0, 1'b1, ACT_TEST,  12'd0,    13'd0, '{1'b0, 12'd0, 1'b0, 13'd0}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd4095, 13'd0, '{1'b0, 12'd0, 1'b0, 13'd1}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b0, 12'd1, 1'b0, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_TEST,  12'd1,    13'd0, '{1'b0, 12'd0, 1'b1, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_TEST,  12'd4095, 13'd0, '{1'b0, 12'd0, 1'b0, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_FREE,  12'd4095, 13'd0, '{1'b0, 12'd0, 1'b0, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_FREE,  12'd0,    13'd0, '{1'b0, 12'd0, 1'b1, 13'd1}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd2730, 13'd0, '{1'b0, 12'd0, 1'b0, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b0, 12'd2, 1'b0, 13'd3}});
    // clear ignores its block number
    directed_rows.push_back('{1'b0, 1'b1, ACT_CLEAR, 12'd4095, 13'd0, '{1'b0, 12'd0, 1'b0, 13'd0}});
    // total of zero: allocate is always full
    directed_rows.push_back('{1'b1, 1'b0, ACT_TEST,  12'd0,    13'd0, '0});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b1, 12'd0, 1'b0, 13'd0}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_TEST,  12'd2730, 13'd0, '{1'b0, 12'd0, 1'b0, 13'd0}});
    // tiny total, run it to full
    directed_rows.push_back('{1'b1, 1'b0, ACT_TEST,  12'd0,    13'd3, '0});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b0, 12'd0, 1'b0, 13'd1}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b0, 12'd1, 1'b0, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b0, 12'd2, 1'b0, 13'd3}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b1, 12'd0, 1'b0, 13'd3}});
    // shrink the total: bits above it are still tested and freed
    directed_rows.push_back('{1'b1, 1'b0, ACT_TEST,  12'd0,    13'd1, '0});
    directed_rows.push_back('{1'b0, 1'b1, ACT_TEST,  12'd2,    13'd0, '{1'b0, 12'd0, 1'b1, 13'd3}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_FREE,  12'd2,    13'd0, '{1'b0, 12'd0, 1'b1, 13'd2}});
    directed_rows.push_back('{1'b0, 1'b1, ACT_ALLOC, 12'd0,    13'd0, '{1'b1, 12'd0, 1'b0, 13'd2}});
    // total above the map size, all register bits high
    directed_rows.push_back('{1'b1, 1'b0, ACT_TEST,  12'd0,    13'd8191, '0});
    directed_rows.push_back('{1'b0, 1'b0, ACT_ALLOC, 12'd0,    13'd0, '0});
    directed_rows.push_back('{1'b0, 1'b0, ACT_FREE,  12'd1365, 13'd0, '0});
    directed_rows.push_back('{1'b1, 1'b0, ACT_TEST,  12'd0,    13'd4096, '0});

    // hold reset, then release it; the block then runs its own clearing pass
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_gap_pct     = 34;
    receiver_stall_pct = 34;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        settle();
        write_total(row.total);
      end else begin
        issue_request(row.act, row.blk, row.typed, row.want);
      end
    end

    // fill a small window, hit full at its top, then poke a hole and refill it
    settle();
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    write_total(13'(FILL_BLOCKS));
    issue_request(ACT_CLEAR, '0, 1'b0, '0);
    for (int n = 0; n <= FILL_BLOCKS; n++) issue_request(ACT_ALLOC, '0, 1'b0, '0);
    settle();
    write_total(13'd8191);
    issue_request(ACT_ALLOC, '0, 1'b0, '0);
    blk = 12'($urandom_range(FILL_BLOCKS - 1, 0));
    issue_request(ACT_FREE, blk, 1'b0, '0);
    issue_request(ACT_TEST, blk, 1'b0, '0);
    issue_request(ACT_ALLOC, '0, 1'b0, '0);
    issue_request(ACT_CLEAR, '0, 1'b0, '0);

    // random phases: each with its own backpressure mix and total
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       total = 13'd4096;
        1:       total = 13'($urandom_range(96, 1));
        2:       total = 13'd8191;
        default: total = 13'($urandom_range(4095, 97));
      endcase
      write_total(total);
      sender_gap_pct     = phase_gap_pct[p];
      receiver_stall_pct = phase_stall_pct[p];
      for (int n = 0; n < PHASE_REQS; n++) begin
        roll = $urandom_range(99, 0);
        if (roll < 48) act = ACT_ALLOC;
        else if (roll < 72) act = ACT_FREE;
        else if (roll < 97) act = ACT_TEST;
        else act = ACT_CLEAR;
        // mostly aim at the allocated region so frees and tests hit used bits
        hi = int'(shadow_count) + 16;
        if (hi > MAP_BLOCKS - 1) hi = MAP_BLOCKS - 1;
        if ($urandom_range(9, 0) < 7) blk = 12'($urandom_range(hi, 0));
        else blk = 12'($urandom());
        issue_request(act, blk, 1'b0, '0);
      end
    end

    settle();
    repeat (140) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d full reports, highest grant %0d",
             requests_sent, results_seen, full_reports, grant_peak);
    $display("directed corners, a small window filled to full and %0d backpressure phases",
             PHASES);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", error_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_word_search.sv
hw/rtl/bitmap_block_allocator_top.sv
tb/sv/tb_top.sv
